### hdl/movdec_pkg.sv
// shared types and constants for the mov subset decoder
package movdec_pkg;

  localparam logic [7:0] OP_RM_REG    = 8'h88;
  localparam logic [7:0] OP_ACC       = 8'hA0;
  localparam logic [7:0] OP_IMM_REG   = 8'hB0;
  localparam logic [7:0] OP_IMM_RM    = 8'hC6;
  localparam logic [7:0] MASK_RM_REG  = 8'hFC;
  localparam logic [7:0] MASK_ACC     = 8'hFC;
  localparam logic [7:0] MASK_IMM_REG = 8'hF0;
  localparam logic [7:0] MASK_IMM_RM  = 8'hFE;
  localparam logic [2:0] RM_DIRECT    = 3'b110;
  localparam logic [7:0] IMM_REG_WIDE = 8'b0000_1000;

  localparam int STORE_DEPTH = 5;
  localparam int MAX_BYTES   = 6;

  typedef enum logic [2:0] {
    FORM_RM_REG     = 3'd0,
    FORM_IMM_REG    = 3'd1,
    FORM_IMM_RM     = 3'd2,
    FORM_MEM_TO_ACC = 3'd3,
    FORM_ACC_TO_MEM = 3'd4
  } form_t;

  typedef logic [MAX_BYTES-1:0][7:0] insn_bytes_t;

  typedef struct packed {
    logic        fire;
    insn_bytes_t bytes;
    logic [2:0]  count;
  } insn_beat_t;

  typedef struct packed {
    logic               status;
    form_t              form;
    logic [7:0]         opcode;
    logic               wide;
    logic               to_register;
    logic [2:0]         reg_index;
    logic [1:0]         mod_field;
    logic [2:0]         rm_field;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         length;
  } record_t;

endpackage

### hdl/movdec_byte_if.sv
// code byte channel interface
interface movdec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

### hdl/movdec_rec_if.sv
// decoded record channel interface
interface movdec_rec_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [2:0]         form;
  logic [7:0]         opcode;
  logic               wide;
  logic               to_register;
  logic [2:0]         reg_index;
  logic [1:0]         mod_field;
  logic [2:0]         rm_field;
  logic               direct_address;
  logic signed [15:0] displacement;
  logic [15:0]        immediate;
  logic [2:0]         length;

  modport source (
    output valid, output status, output form, output opcode, output wide,
    output to_register, output reg_index, output mod_field, output rm_field,
    output direct_address, output displacement, output immediate, output length,
    input ready
  );
  modport sink (
    input valid, input status, input form, input opcode, input wide,
    input to_register, input reg_index, input mod_field, input rm_field,
    input direct_address, input displacement, input immediate, input length,
    output ready
  );
endinterface

### hdl/movdec_collect.sv
// byte collector: holds instruction bytes and works out the length
module movdec_collect import movdec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] code_byte,
  output insn_beat_t beat
);

  logic [STORE_DEPTH-1:0][7:0] store;
  logic [2:0] held;
  logic [2:0] need;
  logic [2:0] need_next;
  logic [2:0] cnt;
  logic [2:0] disp_n;
  logic [7:0] op;

  always_comb begin
    op  = (held == 3'd0) ? code_byte : store[0];
    cnt = held + 3'd1;

    case (code_byte[7:6])
      2'd0:    disp_n = (code_byte[2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
      2'd1:    disp_n = 3'd1;
      2'd2:    disp_n = 3'd2;
      default: disp_n = 3'd0;
    endcase

    need_next = need;
    if (held == 3'd0) begin
      if ((op & MASK_ACC) == OP_ACC) begin
        need_next = 3'd3;
      end else if ((op & MASK_IMM_REG) == OP_IMM_REG) begin
        need_next = ((op & IMM_REG_WIDE) != 8'd0) ? 3'd3 : 3'd2;
      end else if ((op & MASK_RM_REG) == OP_RM_REG || (op & MASK_IMM_RM) == OP_IMM_RM) begin
        need_next = 3'd0;
      end else begin
        need_next = 3'd1;
      end
    end else if (need == 3'd0) begin
      if ((op & MASK_IMM_RM) == OP_IMM_RM) begin
        need_next = 3'd2 + disp_n + (op[0] ? 3'd2 : 3'd1);
      end else begin
        need_next = 3'd2 + disp_n;
      end
    end

    beat.fire  = accept && (need_next != 3'd0) && (cnt >= need_next);
    beat.count = cnt;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (i < STORE_DEPTH && 3'(i) < held) begin
        beat.bytes[i] = store[i];
      end else if (3'(i) == held) begin
        beat.bytes[i] = code_byte;
      end else begin
        beat.bytes[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 3'd0;
      need <= 3'd0;
    end else if (accept) begin
      if (beat.fire) begin
        held <= 3'd0;
        need <= 3'd0;
      end else begin
        held <= cnt;
        need <= need_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !beat.fire) begin
      store[held] <= code_byte;
    end
  end

endmodule

### hdl/movdec_fields.sv
// field decode of a complete instruction into a record
module movdec_fields import movdec_pkg::*; (
  input  insn_beat_t beat,
  output record_t    rec
);

  logic [7:0] op;
  logic [7:0] m;
  logic [2:0] p;
  logic [2:0] p_hi;
  logic       is_direct;

  always_comb begin
    op        = beat.bytes[0];
    m         = beat.bytes[1];
    p         = 3'd2;
    is_direct = (m[7:6] == 2'd0) && (m[2:0] == RM_DIRECT);

    rec                = '0;
    rec.opcode         = op;
    rec.length         = beat.count;

    if ((op & MASK_RM_REG) == OP_RM_REG || (op & MASK_IMM_RM) == OP_IMM_RM) begin
      rec.wide      = op[0];
      rec.mod_field = m[7:6];
      rec.reg_index = m[5:3];
      rec.rm_field  = m[2:0];
      if (is_direct) begin
        rec.direct_address = 1'b1;
        p = 3'd4;
      end else if (m[7:6] == 2'd1) begin
        rec.displacement = {{8{beat.bytes[2][7]}}, beat.bytes[2]};
        p = 3'd3;
      end else if (m[7:6] == 2'd2) begin
        rec.displacement = {beat.bytes[3], beat.bytes[2]};
        p = 3'd4;
      end
      if ((op & MASK_RM_REG) == OP_RM_REG) begin
        rec.form        = FORM_RM_REG;
        rec.to_register = op[1];
        if (is_direct) begin
          rec.immediate = {beat.bytes[3], beat.bytes[2]};
        end
      end else begin
        rec.form = FORM_IMM_RM;
        if (is_direct) begin
          rec.displacement = {beat.bytes[3], beat.bytes[2]};
        end
        rec.immediate[7:0] = beat.bytes[p];
        if (op[0]) begin
          rec.immediate[15:8] = beat.bytes[p_hi];
        end
      end
    end else if ((op & MASK_IMM_REG) == OP_IMM_REG) begin
      rec.form           = FORM_IMM_REG;
      rec.wide           = ((op & IMM_REG_WIDE) != 8'd0);
      rec.to_register    = 1'b1;
      rec.reg_index      = op[2:0];
      rec.immediate[7:0] = beat.bytes[1];
      if (rec.wide) begin
        rec.immediate[15:8] = beat.bytes[2];
      end
    end else if ((op & MASK_ACC) == OP_ACC) begin
      rec.form           = op[1] ? FORM_ACC_TO_MEM : FORM_MEM_TO_ACC;
      rec.wide           = op[0];
      rec.to_register    = !op[1];
      rec.direct_address = 1'b1;
      rec.immediate      = {beat.bytes[2], beat.bytes[1]};
    end else begin
      rec.status = 1'b1;
      rec.length = 3'd1;
    end
  end

  assign p_hi = p + 3'd1;

endmodule

### hdl/mov_instruction_decoder_8086_top.sv
// top level of the 8086 mov subset decoder
// takes one code byte per cycle; the record of an instruction appears in the cycle after
// the beat that carries its last byte, from the result register
// throughput is one byte per cycle while the receiver takes records; a record that
// waits untaken in the single result register holds off the byte channel
// synchronous reset clears the byte count, the length and the result valid
module mov_instruction_decoder_8086_top import movdec_pkg::*; (
  input logic          clk,
  input logic          rst,
  movdec_byte_if.sink  code,
  movdec_rec_if.source record
);

  insn_beat_t beat;
  record_t    rec_next;
  record_t    rec;
  logic       rec_valid;
  logic       accept;

  assign code.ready = !rec_valid || record.ready;
  assign accept     = code.valid && code.ready;

  movdec_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_byte (code.code_byte),
    .beat      (beat)
  );

  movdec_fields u_fields (
    .beat (beat),
    .rec  (rec_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (accept && beat.fire) begin
      rec_valid <= 1'b1;
    end else if (record.ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && beat.fire) begin
      rec <= rec_next;
    end
  end

  assign record.valid          = rec_valid;
  assign record.status         = rec.status;
  assign record.form           = rec.form;
  assign record.opcode         = rec.opcode;
  assign record.wide           = rec.wide;
  assign record.to_register    = rec.to_register;
  assign record.reg_index      = rec.reg_index;
  assign record.mod_field      = rec.mod_field;
  assign record.rm_field       = rec.rm_field;
  assign record.direct_address = rec.direct_address;
  assign record.displacement   = rec.displacement;
  assign record.immediate      = rec.immediate;
  assign record.length         = rec.length;

  // unknown opcodes consume one byte
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    rec_valid && rec.status |-> rec.length == 3'd1)
    else $error("unknown record with length other than one");

  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    accept && beat.fire |=> rec_valid)
    else $error("completed instruction did not raise record valid");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !rec_valid |-> code.ready)
    else $error("byte channel stalled with empty result register");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> rec.length != 3'd0 && rec.length != 3'd7)
    else $error("record length out of range");

endmodule

### dv/mov_instruction_decoder_8086_top_tb.sv
// testbench for the 8086 mov subset decoder: directed forms, backpressure and random code streams
`timescale 1ns / 1ps

module mov_instruction_decoder_8086_top_tb;
  import movdec_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS_PER_PHASE = 360;

  localparam logic [1:0] MOD_MEM     = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP16  = 2'd2;
  localparam logic [1:0] MOD_REG     = 2'd3;

  logic clk;
  logic rst;

  movdec_byte_if byte_ch ();
  movdec_rec_if  rec_ch ();

  mov_instruction_decoder_8086_top dut (
    .clk    (clk),
    .rst    (rst),
    .code   (byte_ch),
    .record (rec_ch)
  );

  record_t    expected_records[$];
  record_t    next_record;
  logic [7:0] insn_store [0:STORE_DEPTH-1];
  logic [2:0] insn_held;
  logic [2:0] insn_need;

  int error_count;
  int cycle_count;
  int beat_count;
  int send_idle_pct;
  int recv_stall_pct;
  int long_hold_left;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic is_modrm_op(input logic [7:0] op);
    return ((op & MASK_RM_REG) == OP_RM_REG) || ((op & MASK_IMM_RM) == OP_IMM_RM);
  endfunction

  // mirror of the decoder: collects bytes and queues the record of each finished instruction
  task automatic decode_byte(input logic [7:0] b);
    logic [7:0] bytes_in [0:7];
    logic [2:0] held;
    logic [2:0] need;
    logic [2:0] count;
    logic [2:0] extra;
    logic [7:0] op;
    logic [7:0] modrm;
    logic [15:0] addr;
    int         p;
    record_t    rec;
    held = insn_held;
    need = insn_need;
    foreach (bytes_in[i]) bytes_in[i] = 8'h00;
    for (int i = 0; i < held; i++) bytes_in[i] = insn_store[i];
    bytes_in[held] = b;
    count = held + 3'd1;
    op = bytes_in[0];

    if (held == 3'd0) begin
      if ((op & MASK_ACC) == OP_ACC) need = 3'd3;
      else if ((op & MASK_IMM_REG) == OP_IMM_REG) need = |(op & IMM_REG_WIDE) ? 3'd3 : 3'd2;
      else if (is_modrm_op(op)) need = 3'd0;
      else need = 3'd1;
    end else if (need == 3'd0) begin
      case (b[7:6])
        MOD_MEM:    extra = (b[2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
        MOD_DISP8:  extra = 3'd1;
        MOD_DISP16: extra = 3'd2;
        default:    extra = 3'd0;
      endcase
      need = 3'd2 + extra;
      if ((op & MASK_IMM_RM) == OP_IMM_RM) need = need + (op[0] ? 3'd2 : 3'd1);
    end

    if (need != 3'd0 && count >= need) begin
      rec = '0;
      rec.opcode = op;
      rec.length = count;
      if (is_modrm_op(op)) begin
        modrm = bytes_in[1];
        addr = 16'h0000;
        p = 2;
        rec.wide = op[0];
        rec.mod_field = modrm[7:6];
        rec.reg_index = modrm[5:3];
        rec.rm_field = modrm[2:0];
        if (modrm[7:6] == MOD_MEM && modrm[2:0] == RM_DIRECT) begin
          rec.direct_address = 1'b1;
          addr = {bytes_in[3], bytes_in[2]};
          p = 4;
        end else if (modrm[7:6] == MOD_DISP8) begin
          rec.displacement = {{8{bytes_in[2][7]}}, bytes_in[2]};
          p = 3;
        end else if (modrm[7:6] == MOD_DISP16) begin
          rec.displacement = {bytes_in[3], bytes_in[2]};
          p = 4;
        end
        if ((op & MASK_RM_REG) == OP_RM_REG) begin
          rec.form = FORM_RM_REG;
          rec.to_register = op[1];
          if (rec.direct_address) rec.immediate = addr;
        end else begin
          rec.form = FORM_IMM_RM;
          rec.to_register = 1'b0;
          if (rec.direct_address) rec.displacement = addr;
          rec.immediate = {rec.wide ? bytes_in[p+1] : 8'h00, bytes_in[p]};
        end
      end else if ((op & MASK_IMM_REG) == OP_IMM_REG) begin
        rec.form = FORM_IMM_REG;
        rec.wide = |(op & IMM_REG_WIDE);
        rec.to_register = 1'b1;
        rec.reg_index = op[2:0];
        rec.immediate = {rec.wide ? bytes_in[2] : 8'h00, bytes_in[1]};
      end else if ((op & MASK_ACC) == OP_ACC) begin
        rec.form = op[1] ? FORM_ACC_TO_MEM : FORM_MEM_TO_ACC;
        rec.wide = op[0];
        rec.to_register = ~op[1];
        rec.direct_address = 1'b1;
        rec.immediate = {bytes_in[2], bytes_in[1]};
      end else begin
        rec.status = 1'b1;
        rec.length = 3'd1;
      end
      expected_records.push_back(rec);
      insn_held = 3'd0;
      insn_need = 3'd0;
    end else begin
      insn_store[held] = b;
      insn_held = count;
      insn_need = need;
    end
  endtask

  task automatic send_code_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.code_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    beat_count++;
    decode_byte(b);
  endtask

  task automatic send_sequence(input logic [7:0] seq[$]);
    foreach (seq[i]) send_code_byte(seq[i]);
  endtask

  // mostly well-formed mov instructions with random content, the rest arbitrary bytes
  task automatic send_random_insn();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 30) b = OP_RM_REG | 8'($urandom_range(3));
    else if (pick < 50) b = OP_IMM_REG | 8'($urandom_range(15));
    else if (pick < 70) b = OP_IMM_RM | 8'($urandom_range(1));
    else if (pick < 82) b = OP_ACC | 8'($urandom_range(3));
    else b = 8'($urandom_range(255));
    send_code_byte(b);
    while (insn_held != 3'd0) begin
      b = 8'($urandom_range(255));
      if (insn_held == 3'd1 && insn_need == 3'd0 && $urandom_range(3) == 0)
        b[2:0] = RM_DIRECT;
      send_code_byte(b);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // record checker and receiver ready
  always @(posedge clk) begin
    if (!rst && rec_ch.valid && rec_ch.ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record, expected none got opcode %h", $time, rec_ch.opcode);
        error_count++;
      end else begin
        next_record = expected_records.pop_front();
        check_field("status", 16'(next_record.status), 16'(rec_ch.status));
        check_field("form", 16'(next_record.form), 16'(rec_ch.form));
        check_field("opcode", 16'(next_record.opcode), 16'(rec_ch.opcode));
        check_field("wide", 16'(next_record.wide), 16'(rec_ch.wide));
        check_field("to_register", 16'(next_record.to_register), 16'(rec_ch.to_register));
        check_field("reg_index", 16'(next_record.reg_index), 16'(rec_ch.reg_index));
        check_field("mod_field", 16'(next_record.mod_field), 16'(rec_ch.mod_field));
        check_field("rm_field", 16'(next_record.rm_field), 16'(rec_ch.rm_field));
        check_field("direct_address", 16'(next_record.direct_address),
                    16'(rec_ch.direct_address));
        check_field("displacement", next_record.displacement, rec_ch.displacement);
        check_field("immediate", next_record.immediate, rec_ch.immediate);
        check_field("length", 16'(next_record.length), 16'(rec_ch.length));
      end
    end
    if (long_hold_left > 0) begin
      rec_ch.ready <= 1'b0;
      long_hold_left--;
    end else begin
      rec_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mov_instruction_decoder_8086_top_tb: errors");
      $finish;
    end
  end

  task automatic test_rm_reg_forms();
    send_sequence('{8'h89, 8'h47, 8'h80});
    send_sequence('{8'h8A, 8'h06, 8'h34, 8'h12});
  endtask

  task automatic test_imm_reg_forms();
    send_sequence('{8'hB0, 8'hFF});
    send_sequence('{8'hBF, 8'h00, 8'h80});
  endtask

  // direct address with wide immediate, then register mode with a nonzero reg field
  task automatic test_imm_rm_forms();
    send_sequence('{8'hC7, 8'h06, 8'hEF, 8'hBE, 8'hAD, 8'hDE});
    send_sequence('{8'hC6, 8'hFB, 8'h7F});
  endtask

  task automatic test_acc_forms();
    send_sequence('{8'hA1, 8'hFF, 8'hFF});
    send_sequence('{8'hA2, 8'h00, 8'h00});
  endtask

  task automatic test_unknown_opcodes();
    send_sequence('{8'h8E, 8'h00, 8'hFF});
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_left = 150;
    while (long_hold_left > 100) send_random_insn();
    repeat (10) send_random_insn();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_stall_pct = 25;
    repeat (6) send_random_insn();
    byte_ch.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (6) send_random_insn();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int stop_at;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = beat_count + RANDOM_BEATS_PER_PHASE;
    while (beat_count < stop_at) send_random_insn();
  endtask

  initial begin
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.code_byte = 8'h00;
    rec_ch.ready = 1'b0;
    insn_held = 3'd0;
    insn_need = 3'd0;
    error_count = 0;
    cycle_count = 0;
    beat_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_rm_reg_forms();
    test_imm_reg_forms();
    test_imm_rm_forms();
    test_acc_forms();
    test_unknown_opcodes();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(0, 0);
    test_random_traffic(72, 0);
    test_random_traffic(0, 72);
    test_random_traffic(25, 25);

    byte_ch.valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_records.size() == 0) begin
      $display("mov_instruction_decoder_8086_top_tb: clean");
    end else begin
      $display("mov_instruction_decoder_8086_top_tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/movdec_pkg.sv
hdl/movdec_byte_if.sv
hdl/movdec_rec_if.sv
hdl/movdec_collect.sv
hdl/movdec_fields.sv
hdl/mov_instruction_decoder_8086_top.sv
dv/mov_instruction_decoder_8086_top_tb.sv
